FILE: design/deriche_line_filter_core_defines.svh
// assertion macros for the deriche line filter core
`ifndef DERICHE_LINE_FILTER_CORE_DEFINES_SVH
`define DERICHE_LINE_FILTER_CORE_DEFINES_SVH

// same-cycle implication check
`define DLF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlf same-cycle check failed");

// next-cycle implication check
`define DLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlf next-cycle check failed");

`endif

FILE: design/dlf_pkg.sv
// shared types and constants for the deriche line filter
package dlf_pkg;

   localparam int MAX_LEN_DEF = 64;

   localparam int SAMPLE_W   = 32;
   localparam int COEF_W     = 32;
   localparam int IDX_W      = 6;
   localparam int ERR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 64;
   localparam int ACC_W      = 66;
   localparam int FRAC_BITS  = 28;

   typedef logic [ERR_W-1:0] err_type;
   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_SHORT = 2'd1;
   localparam err_type ERR_TRUNC = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FWD_A    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_B    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BWD_A    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BWD_B    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB_A     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FB_B     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ODD_GAIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ODD_MODE = 3'd7;

   // 1.0 in q4.28
   localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic neg;
   } mac_ctl_type;

endpackage

FILE: design/dlf_mac.sv
// shared multiply-accumulate unit with round-half-up and saturation
module dlf_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dlf_pkg::mac_ctl_type                   ctl,
   input  logic signed [dlf_pkg::COEF_W-1:0]      coef,
   input  logic signed [dlf_pkg::SAMPLE_W-1:0]    operand,
   output logic signed [dlf_pkg::SAMPLE_W-1:0]    result
);

   localparam int ACC_W  = dlf_pkg::ACC_W;
   localparam int PROD_W = dlf_pkg::PROD_W;

   localparam logic signed [ACC_W-1:0] RND_HALF =
      ACC_W'(66'd1 << (dlf_pkg::FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(66'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(66'sd1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff, prod_vld_in;
   logic                     prod_neg_ff, prod_neg_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [ACC_W-1:0]  acc_shr;

   // stage 1: one 32x32 product
   always_comb begin
      prod_in     = coef * operand;
      prod_vld_in = ctl.mul_en;
      prod_neg_in = ctl.neg;
   end

   // stage 2: exact accumulate
   always_comb begin
      prod_ext = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      acc_in   = ctl.clear ? '0 : acc_ff;
      if (prod_vld_ff) begin
         if (prod_neg_ff) begin
            acc_in = acc_ff - prod_ext;
         end else begin
            acc_in = acc_ff + prod_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_neg_ff <= prod_neg_in;
      acc_ff      <= acc_in;
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   // round once, halves up, then clamp
   always_comb begin
      acc_rnd = acc_ff + RND_HALF;
      acc_shr = acc_rnd >>> dlf_pkg::FRAC_BITS;
      if (acc_shr > SAT_HI) begin
         result = SAT_HI[dlf_pkg::SAMPLE_W-1:0];
      end else if (acc_shr < SAT_LO) begin
         result = SAT_LO[dlf_pkg::SAMPLE_W-1:0];
      end else begin
         result = acc_shr[dlf_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

FILE: design/deriche_line_filter_core.sv
// deriche second-order recursive line filter, top level
// Samples of one line arrive one beat at a time on req_, the last one marked by
// req_line_end, and are stored as they come: a beat that does not end the line
// leaves req_ready high. When the line ends the block drops req_ready and runs
// three passes over the stored line through one shared 32x32 multiplier with a
// 66-bit accumulator: the causal recursion (per sample: read, four products,
// drain, write back), the anti-causal recursion from the line end (the same
// steps for every sample but the end one, which is zero) and the combine
// (per sample: read, two products, drain, write back, then the rsp_ handshake,
// which waits out any back-pressure on rsp_). A short line gives its result in
// the cycle after its last beat. The multiplier is the only arithmetic unit of
// the filter. Results come out in line order with their index; lines shorter
// than three samples give one result flagged too short, and samples past MAX_LEN
// are dropped with every result of that line flagged truncated. Coefficients on
// csr_ are q4.28, samples q16.16; write them only while the block is idle.
`include "deriche_line_filter_core_defines.svh"

module deriche_line_filter_core #(
   parameter int MAX_LEN = dlf_pkg::MAX_LEN_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [dlf_pkg::SAMPLE_W-1:0]     req_sample_in,
   input  logic                                    req_line_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dlf_pkg::SAMPLE_W-1:0]     rsp_sample_out,
   output logic [dlf_pkg::IDX_W-1:0]               rsp_out_index,
   output logic                                    rsp_out_last,
   output logic [dlf_pkg::ERR_W-1:0]               rsp_line_error,
   input  logic                                    csr_wen,
   input  logic [dlf_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [dlf_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int SW     = dlf_pkg::SAMPLE_W;
   localparam int CW     = dlf_pkg::COEF_W;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LEN);
   localparam logic [CNT_W-1:0] MIN_LINE = CNT_W'(3);

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_WAIT = 6'b001000,
      ST_WB   = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // which pass over the line is running
   typedef enum logic [1:0] {
      PASS_CAUSAL = 2'd0,
      PASS_ANTI   = 2'd1,
      PASS_COMB   = 2'd2
   } pass_type;

   // configuration
   logic signed [CW-1:0] fwd_a_ff, fwd_a_in;
   logic signed [CW-1:0] fwd_b_ff, fwd_b_in;
   logic signed [CW-1:0] bwd_a_ff, bwd_a_in;
   logic signed [CW-1:0] bwd_b_ff, bwd_b_in;
   logic signed [CW-1:0] fb_a_ff, fb_a_in;
   logic signed [CW-1:0] fb_b_ff, fb_b_in;
   logic signed [CW-1:0] gain_ff, gain_in;
   logic                 odd_ff, odd_in;

   // sequencer and line bookkeeping
   state_type            state_ff, state_in;
   pass_type             pass_ff, pass_in;
   logic [1:0]           term_ff, term_in;
   logic [ADDR_W-1:0]    k_ff, k_in;
   logic [ADDR_W-1:0]    last_idx_ff, last_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   dlf_pkg::err_type     err_ff, err_in;

   // recursion history: previous sample and the two previous outputs
   logic signed [SW-1:0] x_hist_ff, x_hist_in;
   logic signed [SW-1:0] y1_ff, y1_in;
   logic signed [SW-1:0] y2_ff, y2_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_sample_ff, rsp_sample_in;
   logic [ADDR_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;
   dlf_pkg::err_type     rsp_err_ff, rsp_err_in;

   // line stores
   logic signed [SW-1:0] sample_mem [MAX_LEN];
   logic signed [SW-1:0] causal_mem [MAX_LEN];
   logic signed [SW-1:0] anti_mem [MAX_LEN];

   logic                 samp_we;
   logic [ADDR_W-1:0]    samp_waddr;
   logic                 samp_re;
   logic [ADDR_W-1:0]    samp_raddr;
   logic signed [SW-1:0] samp_rd_ff;
   logic                 causal_we;
   logic                 causal_re;
   logic signed [SW-1:0] causal_rd_ff;
   logic                 anti_we;
   logic [ADDR_W-1:0]    anti_waddr;
   logic signed [SW-1:0] anti_wdata;
   logic                 anti_re;
   logic signed [SW-1:0] anti_rd_ff;

   // shared multiply-accumulate
   dlf_pkg::mac_ctl_type mac_ctl;
   logic signed [CW-1:0] mac_coef;
   logic signed [SW-1:0] mac_op;
   logic signed [SW-1:0] mac_res;

   logic                 req_accept;
   logic                 stored;
   logic [CNT_W-1:0]     line_len;
   logic [CNT_W-1:0]     line_len_m1;
   logic [ADDR_W-1:0]    k_plus1;
   logic [ADDR_W-1:0]    k_minus1;
   logic [1:0]           last_term;
   logic signed [CW-1:0] comb_coef;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_out_index  = dlf_pkg::IDX_W'(rsp_idx_ff);
   assign rsp_out_last   = rsp_last_ff;
   assign rsp_line_error = rsp_err_ff;

   // register writes, bits above a register's width are ignored
   always_comb begin
      fwd_a_in = fwd_a_ff;
      fwd_b_in = fwd_b_ff;
      bwd_a_in = bwd_a_ff;
      bwd_b_in = bwd_b_ff;
      fb_a_in  = fb_a_ff;
      fb_b_in  = fb_b_ff;
      gain_in  = gain_ff;
      odd_in   = odd_ff;
      if (csr_wen) begin
         unique case (csr_index)
            dlf_pkg::REG_FWD_A:    fwd_a_in = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_FWD_B:    fwd_b_in = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_BWD_A:    bwd_a_in = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_BWD_B:    bwd_b_in = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_FB_A:     fb_a_in  = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_FB_B:     fb_b_in  = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_ODD_GAIN: gain_in  = $signed(csr_wdata[CW-1:0]);
            dlf_pkg::REG_ODD_MODE: odd_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // helpers for the sequencer
   assign stored      = (count_ff < CNT_MAX);
   assign line_len    = count_ff + CNT_W'(stored);
   assign line_len_m1 = line_len - CNT_W'(1);
   assign k_plus1     = k_ff + ADDR_W'(1);
   assign k_minus1    = k_ff - ADDR_W'(1);
   assign last_term   = (pass_ff == PASS_COMB) ? 2'd1 : 2'd3;
   // even mode sums both parts through the unit at unity gain
   assign comb_coef   = odd_ff ? gain_ff : dlf_pkg::COEF_ONE;

   // operand selection for the shared unit
   always_comb begin
      mac_coef = fwd_a_ff;
      mac_op   = samp_rd_ff;
      mac_ctl  = '{clear: 1'b0, mul_en: 1'b0, neg: 1'b0};
      if (state_ff == ST_MUL) begin
         mac_ctl.mul_en = 1'b1;
         mac_ctl.clear  = (term_ff == 2'd0);
         if (pass_ff == PASS_COMB) begin
            mac_coef = comb_coef;
            if (term_ff == 2'd0) begin
               mac_op = causal_rd_ff;
            end else begin
               mac_op      = anti_rd_ff;
               mac_ctl.neg = odd_ff;
            end
         end else begin
            case (term_ff)
               2'd0: begin
                  mac_coef = (pass_ff == PASS_ANTI) ? bwd_a_ff : fwd_a_ff;
                  mac_op   = samp_rd_ff;
               end
               2'd1: begin
                  mac_coef = (pass_ff == PASS_ANTI) ? bwd_b_ff : fwd_b_ff;
                  mac_op   = x_hist_ff;
               end
               2'd2: begin
                  mac_coef    = fb_a_ff;
                  mac_op      = y1_ff;
                  mac_ctl.neg = 1'b1;
               end
               default: begin
                  mac_coef    = fb_b_ff;
                  mac_op      = y2_ff;
                  mac_ctl.neg = 1'b1;
               end
            endcase
         end
      end
   end

   dlf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .coef    (mac_coef),
      .operand (mac_op),
      .result  (mac_res)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      term_in       = term_ff;
      k_in          = k_ff;
      last_idx_in   = last_idx_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      err_in        = err_ff;
      x_hist_in     = x_hist_ff;
      y1_in         = y1_ff;
      y2_in         = y2_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      samp_we       = 1'b0;
      samp_waddr    = count_ff[ADDR_W-1:0];
      samp_re       = 1'b0;
      samp_raddr    = k_ff;
      causal_we     = 1'b0;
      causal_re     = 1'b0;
      anti_we       = 1'b0;
      anti_waddr    = k_ff;
      anti_wdata    = mac_res;
      anti_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // store while there is room, otherwise drop and remember it
               samp_we  = stored;
               count_in = stored ? (count_ff + CNT_W'(1)) : count_ff;
               ovf_in   = ovf_ff | ~stored;
               if (req_line_end) begin
                  count_in    = '0;
                  ovf_in      = 1'b0;
                  err_in      = (ovf_ff | ~stored) ? dlf_pkg::ERR_TRUNC : dlf_pkg::ERR_NONE;
                  last_idx_in = line_len_m1[ADDR_W-1:0];
                  if (line_len < MIN_LINE) begin
                     // short line: one flagged zero result
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_idx_in    = '0;
                     rsp_last_in   = 1'b1;
                     rsp_err_in    = dlf_pkg::ERR_SHORT;
                     state_in      = ST_OUT;
                  end else begin
                     // zero history makes the first two steps fall out
                     pass_in   = PASS_CAUSAL;
                     k_in      = '0;
                     x_hist_in = '0;
                     y1_in     = '0;
                     y2_in     = '0;
                     state_in  = ST_RD;
                  end
               end
            end
         end

         ST_RD: begin
            case (pass_ff)
               PASS_CAUSAL: begin
                  samp_re    = 1'b1;
                  samp_raddr = k_ff;
               end
               PASS_ANTI: begin
                  samp_re    = 1'b1;
                  samp_raddr = k_plus1;
               end
               default: begin
                  causal_re = 1'b1;
                  anti_re   = 1'b1;
               end
            endcase
            term_in  = 2'd0;
            state_in = ST_MUL;
         end

         ST_MUL: begin
            if (term_ff == last_term) begin
               state_in = ST_WAIT;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end

         // last product lands in the accumulator
         ST_WAIT: begin
            state_in = ST_WB;
         end

         ST_WB: begin
            case (pass_ff)
               PASS_CAUSAL: begin
                  causal_we = 1'b1;
                  y2_in     = y1_ff;
                  y1_in     = mac_res;
                  x_hist_in = samp_rd_ff;
                  if (k_ff == last_idx_ff) begin
                     // anti-causal part is zero at the line end
                     anti_we    = 1'b1;
                     anti_waddr = last_idx_ff;
                     anti_wdata = '0;
                     pass_in    = PASS_ANTI;
                     k_in       = k_minus1;
                     x_hist_in  = '0;
                     y1_in      = '0;
                     y2_in      = '0;
                  end else begin
                     k_in = k_plus1;
                  end
                  state_in = ST_RD;
               end
               PASS_ANTI: begin
                  anti_we    = 1'b1;
                  anti_waddr = k_ff;
                  anti_wdata = mac_res;
                  y2_in      = y1_ff;
                  y1_in      = mac_res;
                  x_hist_in  = samp_rd_ff;
                  if (k_ff == '0) begin
                     pass_in = PASS_COMB;
                  end else begin
                     k_in = k_minus1;
                  end
                  state_in = ST_RD;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = mac_res;
                  rsp_idx_in    = k_ff;
                  rsp_last_in   = (k_ff == last_idx_ff);
                  rsp_err_in    = err_ff;
                  state_in      = ST_OUT;
               end
            endcase
         end

         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_plus1;
                  state_in = ST_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pass_ff       <= pass_in;
      term_ff       <= term_in;
      k_ff          <= k_in;
      last_idx_ff   <= last_idx_in;
      err_ff        <= err_in;
      x_hist_ff     <= x_hist_in;
      y1_ff         <= y1_in;
      y2_ff         <= y2_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_a_ff     <= '0;
         fwd_b_ff     <= '0;
         bwd_a_ff     <= '0;
         bwd_b_ff     <= '0;
         fb_a_ff      <= '0;
         fb_b_ff      <= '0;
         gain_ff      <= dlf_pkg::COEF_ONE;
         odd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_a_ff     <= fwd_a_in;
         fwd_b_ff     <= fwd_b_in;
         bwd_a_ff     <= bwd_a_in;
         bwd_b_ff     <= bwd_b_in;
         fb_a_ff      <= fb_a_in;
         fb_b_ff      <= fb_b_in;
         gain_ff      <= gain_in;
         odd_ff       <= odd_in;
      end
   end

   // line stores, one write and one registered read each
   always_ff @(posedge clock) begin
      if (samp_we) begin
         sample_mem[samp_waddr] <= req_sample_in;
      end
      if (samp_re) begin
         samp_rd_ff <= sample_mem[samp_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (causal_we) begin
         causal_mem[k_ff] <= mac_res;
      end
      if (causal_re) begin
         causal_rd_ff <= causal_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (anti_we) begin
         anti_mem[anti_waddr] <= anti_wdata;
      end
      if (anti_re) begin
         anti_rd_ff <= anti_mem[k_ff];
      end
   end

   // no new line while a result is pending
   `DLF_ASSERT_SAME(a_no_req_while_rsp, clock, reset, rsp_valid_ff, !req_ready)
   // the final beat of a line frees the input side
   `DLF_ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_valid && rsp_ready && rsp_out_last, req_ready)
   // a short line never yields more than its single result
   `DLF_ASSERT_SAME(a_short_is_single, clock, reset, rsp_valid && !rsp_out_last, rsp_line_error != dlf_pkg::ERR_SHORT)

endmodule

FILE: dv/tb_top.sv
// testbench for the deriche line filter core: a line-level filter predictor and result checking
module tb_top;

   localparam int MAX_LEN       = dlf_pkg::MAX_LEN_DEF;
   localparam int SAMPLE_W      = dlf_pkg::SAMPLE_W;
   localparam int IDX_W         = dlf_pkg::IDX_W;
   localparam int ERR_W         = dlf_pkg::ERR_W;
   localparam int CSR_IDX_W     = dlf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = dlf_pkg::CSR_DATA_W;
   localparam int FRAC_BITS     = dlf_pkg::FRAC_BITS;
   localparam int SETTLE_CYCLES = 50;       // block is idle well before this after its last beat out
   localparam int DRAIN_LIMIT   = 20000;    // longest line with every stall, many times over
   localparam int HOLD_CYCLES   = 400;      // long output hold for the back-pressure test
   localparam int LIMIT_CYCLES  = 400000;

   // one expected beat on the rsp_ channel
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic [IDX_W-1:0]    index;
      logic                last;
      dlf_pkg::err_type    err;
   } line_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       req_line_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic [IDX_W-1:0]           rsp_out_index;
   logic                       rsp_out_last;
   logic [ERR_W-1:0]           rsp_line_error;
   logic                       csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   deriche_line_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_line_end   (req_line_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_last   (rsp_out_last),
      .rsp_line_error (rsp_line_error),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // filter state as the predictor sees it
   logic signed [SAMPLE_W-1:0] held_samples [$];     // samples of the line in progress
   logic                       tail_dropped = 1'b0;  // a beat past MAX_LEN was seen
   logic [CSR_DATA_W-1:0]      live_regs [8];        // register contents as written
   logic [CSR_DATA_W-1:0]      next_regs [8];        // staged for the next load
   line_result_type            line_results [$];     // results still owed by the block

   // run control and bookkeeping
   bit idling = 1'b1;
   int rsp_hold_left = 0;
   int rsp_gap_left = 0;
   int mismatch_count = 0;
   int lines_seen = 0;
   int short_lines = 0;
   int trunc_lines = 0;
   int beats_in = 0;
   int results_checked = 0;
   int reg_loads = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("tb_top NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------------------------------
   // fixed-point arithmetic of the filter
   // ---------------------------------------------------------------------------------------------

   // full product of a q4.28 coefficient and a q16.16 value, kept wide
   function automatic logic signed [71:0] mul_wide(input logic signed [71:0] c,
                                                   input logic signed [71:0] x);
      return c * x;
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] clamp_q16(input logic signed [71:0] v);
      if (v > 72'sh7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      if (v < -72'sh8000_0000)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // drop 28 fraction bits, halves round up, then clamp
   function automatic logic signed [31:0] round_q28(input logic signed [71:0] acc);
      logic signed [71:0] r;
      r = (acc + 72'sd134217728) >>> FRAC_BITS;
      return clamp_q16(r);
   endfunction

   // takes one accepted beat; on the line end works out every result of the line
   function automatic void predict_beat(input logic signed [SAMPLE_W-1:0] s, input logic le);
      logic signed [31:0] fwd [MAX_LEN];
      logic signed [31:0] bwd [MAX_LEN];
      logic signed [31:0] ca, cb, cc, cd, fa, fb, gain;
      logic signed [71:0] acc;
      line_result_type    res;
      int                 n;

      beats_in++;
      if (held_samples.size() < MAX_LEN)
         held_samples.push_back(s);
      else
         tail_dropped = 1'b1;
      if (!le)
         return;

      n = held_samples.size();
      lines_seen++;
      ca   = live_regs[dlf_pkg::REG_FWD_A];
      cb   = live_regs[dlf_pkg::REG_FWD_B];
      cc   = live_regs[dlf_pkg::REG_BWD_A];
      cd   = live_regs[dlf_pkg::REG_BWD_B];
      fa   = live_regs[dlf_pkg::REG_FB_A];
      fb   = live_regs[dlf_pkg::REG_FB_B];
      gain = live_regs[dlf_pkg::REG_ODD_GAIN];

      if (n < 3) begin
         // too short to filter: one flagged zero result
         res.value = '0;
         res.index = '0;
         res.last  = 1'b1;
         res.err   = dlf_pkg::ERR_SHORT;
         line_results.push_back(res);
         short_lines++;
      end else begin
         if (tail_dropped)
            trunc_lines++;
         // causal pass, start-up terms first
         fwd[0] = round_q28(mul_wide(ca, held_samples[0]));
         fwd[1] = round_q28(mul_wide(ca, held_samples[1]) + mul_wide(cb, held_samples[0])
                            - mul_wide(fa, fwd[0]));
         for (int k = 2; k < n; k++)
            fwd[k] = round_q28(mul_wide(ca, held_samples[k]) + mul_wide(cb, held_samples[k-1])
                               - mul_wide(fa, fwd[k-1]) - mul_wide(fb, fwd[k-2]));
         // anti-causal pass from the line end
         bwd[n-1] = '0;
         bwd[n-2] = round_q28(mul_wide(cc, held_samples[n-1]));
         for (int k = n - 3; k >= 0; k--)
            bwd[k] = round_q28(mul_wide(cc, held_samples[k+1]) + mul_wide(cd, held_samples[k+2])
                               - mul_wide(fa, bwd[k+1]) - mul_wide(fb, bwd[k+2]));
         for (int k = 0; k < n; k++) begin
            acc = fwd[k];
            if (live_regs[dlf_pkg::REG_ODD_MODE][0]) begin
               acc = acc - bwd[k];
               res.value = round_q28(mul_wide(gain, acc));
            end else begin
               acc = acc + bwd[k];
               res.value = clamp_q16(acc);
            end
            res.index = IDX_W'(k);
            res.last  = (k == n - 1);
            res.err   = tail_dropped ? dlf_pkg::ERR_TRUNC : dlf_pkg::ERR_NONE;
            line_results.push_back(res);
         end
      end
      held_samples.delete();
      tail_dropped = 1'b0;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // driving and checking
   // ---------------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s, got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // offers one sample beat, holding it until accepted; called and returns at a falling edge
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic le);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      req_line_end  <= le;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_beat(s, le);
      @(negedge clock);
   endtask

   // mostly modest values, with the extremes and full-range noise mixed in
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return $urandom;
         4:       return 32'($urandom_range(0, 6)) - 32'd3;
         default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   // mostly coefficients within +-0.5, sometimes the extremes or anything
   function automatic logic [CSR_DATA_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom;
         default: return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
      endcase
   endfunction

   // short lines dominate, a few too short and a few longer ones
   function automatic int pick_len();
      case ($urandom_range(0, 19))
         0:       return 1;
         1:       return 2;
         2:       return $urandom_range(20, 40);
         default: return $urandom_range(3, 12);
      endcase
   endfunction

   task automatic send_line(input int len);
      for (int i = 0; i < len; i++)
         push_sample(pick_sample(), i == len - 1);
   endtask

   // waits for every owed result, then lets the block go quiet
   task automatic settle(input int quiet_cycles);
      req_valid <= 1'b0;
      for (int i = 0; i < DRAIN_LIMIT && line_results.size() != 0; i++)
         @(negedge clock);
      repeat (quiet_cycles) @(negedge clock);
   endtask

   // writes all staged registers, one per cycle; only while idle
   task automatic load_regs();
      for (int i = 0; i <= dlf_pkg::REG_ODD_MODE; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= next_regs[i];
         @(negedge clock);
         live_regs[i] = next_regs[i];
      end
      csr_wen <= 1'b0;
      reg_loads++;
   endtask

   // a gentle low-pass pair with negative first feedback
   task automatic stage_unit_regs(input logic odd);
      next_regs[dlf_pkg::REG_FWD_A]    = dlf_pkg::COEF_ONE;
      next_regs[dlf_pkg::REG_FWD_B]    = 32'h0800_0000;
      next_regs[dlf_pkg::REG_BWD_A]    = 32'h0800_0000;
      next_regs[dlf_pkg::REG_BWD_B]    = 32'h0400_0000;
      next_regs[dlf_pkg::REG_FB_A]     = 32'hF800_0000;
      next_regs[dlf_pkg::REG_FB_B]     = 32'h0400_0000;
      next_regs[dlf_pkg::REG_ODD_GAIN] = dlf_pkg::COEF_ONE;
      // upper bits of the mode word must be ignored
      next_regs[dlf_pkg::REG_ODD_MODE] = {31'($urandom_range(0, 32'h7FFF_FFFF)), odd};
   endtask

   // result checking on every rsp_ beat
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_results.size() == 0) begin
            report_mismatch("result beat with nothing owed", rsp_sample_out, '0);
         end else begin
            want = line_results.pop_front();
            results_checked++;
            if (rsp_sample_out !== want.value)
               report_mismatch($sformatf("sample_out at index %0d", want.index),
                               rsp_sample_out, want.value);
            if (rsp_out_index !== want.index)
               report_mismatch("out_index", 32'(rsp_out_index), 32'(want.index));
            if (rsp_out_last !== want.last)
               report_mismatch($sformatf("out_last at index %0d", want.index),
                               32'(rsp_out_last), 32'(want.last));
            if (rsp_line_error !== want.err)
               report_mismatch($sformatf("line_error at index %0d", want.index),
                               32'(rsp_line_error), 32'(want.err));
         end
      end
   end

   // output side: long holds on request, otherwise random stall bursts while idling is on
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_gap_left = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------------

   // registers straight out of reset: zero coefficients, unit gain, even mode
   task automatic test_reset_state();
      push_sample(32'sh0001_0000, 1'b0);
      push_sample(32'sh0002_0000, 1'b0);
      push_sample(32'sh0003_0000, 1'b1);
   endtask

   // short lines, field extremes and both combine modes with known coefficients
   task automatic test_directed_lines();
      settle(SETTLE_CYCLES);
      stage_unit_regs(1'b0);
      load_regs();
      // a lone sample and a pair are both too short
      push_sample(32'sh0005_0000, 1'b1);
      push_sample(32'sh7FFF_FFFF, 1'b0);
      push_sample(32'sh8000_0000, 1'b1);
      // saturation high, then low
      push_sample(32'sh7FFF_FFFF, 1'b0);
      push_sample(32'sh7FFF_FFFF, 1'b0);
      push_sample(32'sh7FFF_FFFF, 1'b1);
      push_sample(32'sh8000_0000, 1'b0);
      push_sample(32'sh8000_0000, 1'b0);
      push_sample(32'sh8000_0000, 1'b1);
      // rounding around zero
      push_sample(32'sh0000_0000, 1'b0);
      push_sample(32'shFFFF_FFFF, 1'b0);
      push_sample(32'sh0000_0001, 1'b0);
      push_sample(32'sh0001_0000, 1'b1);
      // odd mode over a step edge
      settle(SETTLE_CYCLES);
      stage_unit_regs(1'b1);
      load_regs();
      push_sample(32'sh0000_0000, 1'b0);
      push_sample(32'sh0000_0000, 1'b0);
      push_sample(32'sh0004_0000, 1'b0);
      push_sample(32'sh0004_0000, 1'b0);
      push_sample(32'sh0004_0000, 1'b1);
   endtask

   // every coefficient at its top value with the gain at its bottom, then the reverse, in both combine modes
   task automatic test_extreme_coefs();
      settle(SETTLE_CYCLES);
      for (int i = 0; i < dlf_pkg::REG_ODD_MODE; i++)
         next_regs[i] = 32'h7FFF_FFFF;
      next_regs[dlf_pkg::REG_ODD_GAIN] = 32'h8000_0000;
      next_regs[dlf_pkg::REG_ODD_MODE] = 32'hFFFF_FFFF;
      load_regs();
      send_line(5);
      send_line(3);
      settle(SETTLE_CYCLES);
      for (int i = 0; i < dlf_pkg::REG_ODD_MODE; i++)
         next_regs[i] = 32'h8000_0000;
      next_regs[dlf_pkg::REG_ODD_GAIN] = 32'h7FFF_FFFF;
      next_regs[dlf_pkg::REG_ODD_MODE] = 32'hFFFF_FFFE;
      load_regs();
      send_line(5);
      next_regs[dlf_pkg::REG_ODD_MODE] = 32'h0000_0001;
      settle(SETTLE_CYCLES);
      load_regs();
      send_line(4);
   endtask

   // a line one beat past the store, so the marked last beat is dropped
   task automatic test_line_limits();
      settle(SETTLE_CYCLES);
      stage_unit_regs(1'b1);
      load_regs();
      send_line(MAX_LEN + 1);
   endtask

   // output held off for a long stretch while lines keep coming, so the input stalls
   task automatic test_output_stall();
      settle(SETTLE_CYCLES);
      idling = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 4; i++)
         send_line($urandom_range(6, 10));
   endtask

   // random settings per phase, random lines; the closing phases run without idling
   task automatic test_random_lines();
      int phase_beats;
      int len;
      for (int phase = 0; phase < 4; phase++) begin
         settle(SETTLE_CYCLES);
         for (int i = 0; i < dlf_pkg::REG_ODD_MODE; i++)
            next_regs[i] = pick_coef();
         next_regs[dlf_pkg::REG_ODD_MODE] = $urandom;
         load_regs();
         idling = (phase < 2);
         phase_beats = 0;
         while (phase_beats < 10) begin
            len = pick_len();
            send_line(len);
            phase_beats += len;
         end
      end
   endtask

   initial begin
      // reset values of the registers
      live_regs[dlf_pkg::REG_FWD_A]    = '0;
      live_regs[dlf_pkg::REG_FWD_B]    = '0;
      live_regs[dlf_pkg::REG_BWD_A]    = '0;
      live_regs[dlf_pkg::REG_BWD_B]    = '0;
      live_regs[dlf_pkg::REG_FB_A]     = '0;
      live_regs[dlf_pkg::REG_FB_B]     = '0;
      live_regs[dlf_pkg::REG_ODD_GAIN] = dlf_pkg::COEF_ONE;
      live_regs[dlf_pkg::REG_ODD_MODE] = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_directed_lines();
      test_extreme_coefs();
      test_line_limits();
      test_output_stall();
      test_random_lines();

      // drain, then watch for stray beats while the block stays quiet
      settle(MAX_LEN * 20);
      if (line_results.size() != 0)
         report_mismatch("results never delivered", line_results.size(), '0);

      $display("covered %0d lines (%0d short, %0d truncated), %0d beats in, %0d results checked",
               lines_seen, short_lines, trunc_lines, beats_in, results_checked);
      $display("%0d register loads, %0d-cycle output hold, %0d mismatches",
               reg_loads, HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/dlf_pkg.sv
design/dlf_mac.sv
design/deriche_line_filter_core.sv
dv/tb_top.sv
